FILE: design/scta_pkg.sv
// Shared types and constants for the scancode to ASCII line editor.
package scta_pkg;

    localparam int CodeW  = 8;
    localparam int CharW  = 7;
    localparam int CountW = 7;
    localparam int KindW  = 2;

    localparam logic [CodeW-1:0] SC_LSHIFT     = 8'h2A;
    localparam logic [CodeW-1:0] SC_RSHIFT     = 8'h36;
    localparam logic [CodeW-1:0] SC_LSHIFT_BRK = 8'hAA;
    localparam logic [CodeW-1:0] SC_RSHIFT_BRK = 8'hB6;
    localparam logic [CodeW-1:0] SC_CAPS       = 8'h3A;
    localparam logic [CodeW-1:0] SC_ENTER      = 8'h1C;
    localparam logic [CodeW-1:0] SC_BACKSPACE  = 8'h0E;
    localparam logic [CodeW-1:0] SC_SPACE      = 8'h39;

    localparam logic [CountW-1:0] LIMIT_RESET = 7'd79;
    localparam logic [CharW-1:0]  CASE_OFFSET = 7'd32;

    localparam logic [KindW-1:0] KIND_NONE = 2'd0;
    localparam logic [KindW-1:0] KIND_CHAR = 2'd1;
    localparam logic [KindW-1:0] KIND_ENTER = 2'd2;
    localparam logic [KindW-1:0] KIND_BKSP = 2'd3;

    typedef struct packed {
        logic [KindW-1:0]  kind;
        logic [CharW-1:0]  char_code;
        logic [CountW-1:0] line_length;
    } result_t;

endpackage

FILE: design/scta_keymap.sv
// US set-1 make code to ASCII lookup with shift and caps handling.
module scta_keymap (
    input  logic [6:0]               code,
    input  logic                     shift_held,
    input  logic                     caps_on,
    output logic [scta_pkg::CharW-1:0] char_code
);
    import scta_pkg::*;

    logic [CharW-1:0] base_char;
    logic [CharW-1:0] shift_char;
    logic             is_letter;

    always_comb
    begin
        base_char  = '0;
        shift_char = '0;
        is_letter  = 1'b0;
        case (code)
            7'h02: begin base_char = 7'h31; shift_char = 7'h21; end
            7'h03: begin base_char = 7'h32; shift_char = 7'h40; end
            7'h04: begin base_char = 7'h33; shift_char = 7'h23; end
            7'h05: begin base_char = 7'h34; shift_char = 7'h24; end
            7'h06: begin base_char = 7'h35; shift_char = 7'h25; end
            7'h07: begin base_char = 7'h36; shift_char = 7'h5E; end
            7'h08: begin base_char = 7'h37; shift_char = 7'h26; end
            7'h09: begin base_char = 7'h38; shift_char = 7'h2A; end
            7'h0A: begin base_char = 7'h39; shift_char = 7'h28; end
            7'h0B: begin base_char = 7'h30; shift_char = 7'h29; end
            7'h0C: begin base_char = 7'h2D; shift_char = 7'h5F; end
            7'h0D: begin base_char = 7'h3D; shift_char = 7'h2B; end
            7'h10: begin base_char = 7'h71; is_letter = 1'b1; end
            7'h11: begin base_char = 7'h77; is_letter = 1'b1; end
            7'h12: begin base_char = 7'h65; is_letter = 1'b1; end
            7'h13: begin base_char = 7'h72; is_letter = 1'b1; end
            7'h14: begin base_char = 7'h74; is_letter = 1'b1; end
            7'h15: begin base_char = 7'h79; is_letter = 1'b1; end
            7'h16: begin base_char = 7'h75; is_letter = 1'b1; end
            7'h17: begin base_char = 7'h69; is_letter = 1'b1; end
            7'h18: begin base_char = 7'h6F; is_letter = 1'b1; end
            7'h19: begin base_char = 7'h70; is_letter = 1'b1; end
            7'h1A: begin base_char = 7'h5B; shift_char = 7'h7B; end
            7'h1B: begin base_char = 7'h5D; shift_char = 7'h7D; end
            7'h1E: begin base_char = 7'h61; is_letter = 1'b1; end
            7'h1F: begin base_char = 7'h73; is_letter = 1'b1; end
            7'h20: begin base_char = 7'h64; is_letter = 1'b1; end
            7'h21: begin base_char = 7'h66; is_letter = 1'b1; end
            7'h22: begin base_char = 7'h67; is_letter = 1'b1; end
            7'h23: begin base_char = 7'h68; is_letter = 1'b1; end
            7'h24: begin base_char = 7'h6A; is_letter = 1'b1; end
            7'h25: begin base_char = 7'h6B; is_letter = 1'b1; end
            7'h26: begin base_char = 7'h6C; is_letter = 1'b1; end
            7'h27: begin base_char = 7'h3B; shift_char = 7'h3A; end
            7'h2C: begin base_char = 7'h7A; is_letter = 1'b1; end
            7'h2D: begin base_char = 7'h78; is_letter = 1'b1; end
            7'h2E: begin base_char = 7'h63; is_letter = 1'b1; end
            7'h2F: begin base_char = 7'h76; is_letter = 1'b1; end
            7'h30: begin base_char = 7'h62; is_letter = 1'b1; end
            7'h31: begin base_char = 7'h6E; is_letter = 1'b1; end
            7'h32: begin base_char = 7'h6D; is_letter = 1'b1; end
            7'h33: begin base_char = 7'h2C; shift_char = 7'h3C; end
            7'h34: begin base_char = 7'h2E; shift_char = 7'h3E; end
            7'h35: begin base_char = 7'h2F; shift_char = 7'h3F; end
            SC_SPACE[6:0]: begin base_char = 7'h20; shift_char = 7'h20; end
            default: begin base_char = '0; end
        endcase
    end

    always_comb
    begin
        if (is_letter)
        begin
            char_code = (caps_on ^ shift_held) ? (base_char - CASE_OFFSET) : base_char;
        end
        else if (shift_held && (shift_char != '0))
        begin
            char_code = shift_char;
        end
        else
        begin
            char_code = base_char;
        end
    end

endmodule

FILE: design/scta_editor.sv
// Modifier flags, line counter, limit register and per-beat result decode.
module scta_editor (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         step,
    input  logic [scta_pkg::CodeW-1:0]   scancode,
    input  logic                         cfg_write,
    input  logic [scta_pkg::CountW-1:0]  cfg_limit,
    output scta_pkg::result_t            result
);
    import scta_pkg::*;

    logic              shift_reg;
    logic              shift_next;
    logic              caps_reg;
    logic              caps_next;
    logic [CountW-1:0] count_reg;
    logic [CountW-1:0] count_next;
    logic [CountW-1:0] limit_reg;
    logic [CharW-1:0]  mapped_char;

    scta_keymap u_keymap (
        .code       (scancode[6:0]),
        .shift_held (shift_reg),
        .caps_on    (caps_reg),
        .char_code  (mapped_char)
    );

    always_comb
    begin
        shift_next = shift_reg;
        caps_next  = caps_reg;
        if (scancode == SC_LSHIFT || scancode == SC_RSHIFT)
        begin
            shift_next = 1'b1;
        end
        else if (scancode == SC_LSHIFT_BRK || scancode == SC_RSHIFT_BRK)
        begin
            shift_next = 1'b0;
        end
        else if (scancode == SC_CAPS)
        begin
            caps_next = ~caps_reg;
        end
    end

    always_comb
    begin
        count_next         = count_reg;
        result.kind        = KIND_NONE;
        result.char_code   = '0;
        result.line_length = count_reg;
        if (!scancode[CodeW-1])
        begin
            if (scancode == SC_ENTER)
            begin
                result.kind = KIND_ENTER;
                count_next  = '0;
            end
            else if (scancode == SC_BACKSPACE)
            begin
                if (count_reg != '0)
                begin
                    count_next  = count_reg - 1'b1;
                    result.kind = KIND_BKSP;
                end
                result.line_length = count_next;
            end
            else
            begin
                if (mapped_char != '0 && count_reg < limit_reg)
                begin
                    count_next       = count_reg + 1'b1;
                    result.kind      = KIND_CHAR;
                    result.char_code = mapped_char;
                end
                result.line_length = count_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= 1'b0;
            caps_reg  <= 1'b0;
            count_reg <= '0;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            if (step)
            begin
                shift_reg <= shift_next;
                caps_reg  <= caps_next;
                count_reg <= count_next;
            end
            if (cfg_write)
            begin
                limit_reg <= cfg_limit;
            end
        end
    end

    a_char_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.kind == KIND_CHAR) |-> (result.char_code != '0))
        else $error("accepted character with zero code");

    a_char_only_on_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (result.kind != KIND_CHAR) |-> (result.char_code == '0))
        else $error("character code on non-character result");

    a_char_counts_up: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.kind == KIND_CHAR) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("counter did not advance on accepted character");

    a_enter_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (step && scancode == SC_ENTER) |=> (count_reg == '0))
        else $error("counter not cleared by enter");

    a_limit_held: assert property (@(posedge clk) disable iff (!rst_n)
        (step && result.kind == KIND_CHAR) |-> (count_reg < limit_reg))
        else $error("character accepted on full line");

endmodule

FILE: design/scancode_to_ascii_line_editor.sv
// Top level of the PS/2 set-1 scancode to ASCII line editor.
//
// Input channel: in_valid / in_stall with scancode, one raw set-1 byte per beat.
// Output channel: out_valid / out_stall with kind, char_code, line_length,
// exactly one result beat per input beat, in order.
// Config channel: cfg_valid / cfg_ready with line_limit; cfg_ready is always
// high, write only while the block is idle.
// Path: a beat accepted into the input register is decoded from it and
// lands in the output register, where the output channel takes it.
// Throughput: one beat per cycle while the output does not stall, set by the
// single decode step between the input register and the output register.
// Stall: when out_stall holds a full output register, the input register
// keeps its beat and in_stall rises; one beat waits in each register.
// Reset: shift and caps clear, the line count clears, line_limit returns to
// 79, both registers empty.
module scancode_to_ascii_line_editor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [scta_pkg::CodeW-1:0]    scancode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scta_pkg::KindW-1:0]    kind,
    output logic [scta_pkg::CharW-1:0]    char_code,
    output logic [scta_pkg::CountW-1:0]   line_length,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [scta_pkg::CountW-1:0]   line_limit
);
    import scta_pkg::*;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [CodeW-1:0] s1_code_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_data_reg;
    result_t          result;
    logic             advance;
    logic             step;
    logic             in_take;

    assign advance  = !out_valid_reg || !out_stall;
    assign step     = s1_valid_reg && advance;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take || (s1_valid_reg && !advance);
    assign out_valid_next = step || (out_valid_reg && out_stall);

    assign cfg_ready = 1'b1;

    scta_editor u_editor (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .scancode  (s1_code_reg),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_limit (line_limit),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_code_reg <= scancode;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_data_reg.kind;
    assign char_code   = out_data_reg.char_code;
    assign line_length = out_data_reg.line_length;

endmodule
